### rtl/crsc_pkg.sv
// Shared constants and types for the capacitated route split cost unit.
`default_nettype none

package crsc_pkg;

    localparam int COST_W          = 48;
    localparam int DIST_W          = 32;
    localparam int CAP_W           = 32;
    localparam int DEMAND_W        = 16;
    localparam int MAX_CLIENTS_DEF = 1024;
    localparam int DEMAND_BITS_DEF = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(100);
    localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};

    typedef struct packed {
        logic              infeasible;
        logic [COST_W-1:0] total_cost;
    } result_t;

endpackage

`default_nettype wire

### rtl/crsc_store.sv
// Queue (cost, position) memory and window demand memory, with registered read data.
`default_nettype none

module crsc_store
    import crsc_pkg::*;
#(
    parameter int DEPTH = MAX_CLIENTS_DEF,
    parameter int AW    = $clog2(MAX_CLIENTS_DEF),
    parameter int DW    = DEMAND_W
) (
    input  wire                 aclk,
    input  wire                 q_rd_en,
    input  wire  [AW-1:0]       q_rd_addr,
    output logic [COST_W-1:0]   q_rd_cost,
    output logic [AW-1:0]       q_rd_pos,
    input  wire                 q_wr_en,
    input  wire  [AW-1:0]       q_wr_addr,
    input  wire  [COST_W-1:0]   q_wr_cost,
    input  wire  [AW-1:0]       q_wr_pos,
    input  wire                 d_rd_en,
    input  wire  [AW-1:0]       d_rd_addr,
    output logic [DW-1:0]       d_rd_data,
    input  wire                 d_wr_en,
    input  wire  [AW-1:0]       d_wr_addr,
    input  wire  [DW-1:0]       d_wr_data
);

    logic [COST_W-1:0] q_cost_mem [DEPTH];
    logic [AW-1:0]     q_pos_mem  [DEPTH];
    logic [DW-1:0]     d_mem      [DEPTH];

    always_ff @(posedge aclk) begin
        if (q_wr_en) begin
            q_cost_mem[q_wr_addr] <= q_wr_cost;
            q_pos_mem[q_wr_addr]  <= q_wr_pos;
        end
        if (q_rd_en) begin
            q_rd_cost <= q_cost_mem[q_rd_addr];
            q_rd_pos  <= q_pos_mem[q_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (d_wr_en) begin
            d_mem[d_wr_addr] <= d_wr_data;
        end
        if (d_rd_en) begin
            d_rd_data <= d_mem[d_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/crsc_ctrl.sv
// Sequencer: min-queue push/pop, load window drain and tour cost accumulation.
`default_nettype none

module crsc_ctrl
    import crsc_pkg::*;
#(
    parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
    parameter int DEMAND_BITS = DEMAND_BITS_DEF,
    localparam int AW = $clog2(MAX_CLIENTS),
    localparam int CW = $clog2(MAX_CLIENTS + 1),
    localparam int DW = (DEMAND_BITS < DEMAND_W) ? DEMAND_BITS : DEMAND_W
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire  [CAP_W-1:0]    capacity,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [DEMAND_W-1:0] in_demand,
    input  wire  [DIST_W-1:0]   in_from_depot,
    input  wire  [DIST_W-1:0]   in_from_prev,
    input  wire                 in_last,
    input  wire                 out_free,
    output logic                res_valid,
    output result_t             res,
    output logic                q_rd_en,
    output logic [AW-1:0]       q_rd_addr,
    input  wire  [COST_W-1:0]   q_rd_cost,
    input  wire  [AW-1:0]       q_rd_pos,
    output logic                q_wr_en,
    output logic [AW-1:0]       q_wr_addr,
    output logic [COST_W-1:0]   q_wr_cost,
    output logic [AW-1:0]       q_wr_pos,
    output logic                d_rd_en,
    output logic [AW-1:0]       d_rd_addr,
    input  wire  [DW-1:0]       d_rd_data,
    output logic                d_wr_en,
    output logic [AW-1:0]       d_wr_addr,
    output logic [DW-1:0]       d_wr_data
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RDMIN  = 4'd2;
    localparam logic [3:0] S_COST   = 4'd3;
    localparam logic [3:0] S_BRD    = 4'd4;
    localparam logic [3:0] S_BCMP   = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_DEMAND = 4'd7;
    localparam logic [3:0] S_DRD    = 4'd8;
    localparam logic [3:0] S_DSUB   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_TOT1   = 4'd11;
    localparam logic [3:0] S_TOT2   = 4'd12;

    localparam int LW = CAP_W + 1;

    logic [3:0]               state_reg, state_next;
    logic [CW-1:0]            head_reg, head_next;
    logic [CW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            start_reg, start_next;
    logic [AW-1:0]            j_reg, j_next;
    logic [LW-1:0]            load_reg, load_next;
    logic [DIST_W-1:0]        prev_reg, prev_next;
    logic [COST_W-1:0]        tl_reg, tl_next;
    logic                     infeas_reg, infeas_next;

    logic [DW-1:0]            demand_reg, demand_next;
    logic [DIST_W-1:0]        fd_reg, fd_next;
    logic [DIST_W-1:0]        fp_reg, fp_next;
    logic                     last_reg, last_next;
    logic signed [DIST_W+1:0] detour_reg, detour_next;
    logic [COST_W-1:0]        cost_reg, cost_next;
    logic [COST_W-1:0]        sum_reg, sum_next;

    logic                     head_lt_tail;
    logic [COST_W-1:0]        qmin;
    logic signed [COST_W+1:0] cut_cost;
    logic [COST_W:0]          tl_sum;
    logic [COST_W:0]          min_sum;
    logic [COST_W:0]          total_sum;

    assign head_lt_tail = head_reg < tail_reg;
    assign qmin         = head_lt_tail ? q_rd_cost : '0;
    assign cut_cost     = $signed({2'b00, qmin})
                        + $signed({{(COST_W - DIST_W){detour_reg[DIST_W+1]}}, detour_reg});
    assign tl_sum       = {1'b0, tl_reg} + (COST_W + 1)'(fp_reg);
    assign min_sum      = {1'b0, qmin} + {1'b0, tl_reg};
    assign total_sum    = {1'b0, sum_reg} + (COST_W + 1)'(fd_reg);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        start_next  = start_reg;
        j_next      = j_reg;
        load_next   = load_reg;
        prev_next   = prev_reg;
        tl_next     = tl_reg;
        infeas_next = infeas_reg;
        demand_next = demand_reg;
        fd_next     = fd_reg;
        fp_next     = fp_reg;
        last_next   = last_reg;
        detour_next = detour_reg;
        cost_next   = cost_reg;
        sum_next    = sum_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        res.infeasible = infeas_reg;
        res.total_cost = infeas_reg ? '0 : (total_sum[COST_W] ? COST_MAX
                                                               : total_sum[COST_W-1:0]);
        q_rd_en   = 1'b0;
        q_rd_addr = head_reg[AW-1:0];
        q_wr_en   = 1'b0;
        q_wr_addr = tail_reg[AW-1:0];
        q_wr_cost = cost_reg;
        q_wr_pos  = j_reg;
        d_rd_en   = 1'b0;
        d_rd_addr = start_reg[AW-1:0];
        d_wr_en   = 1'b0;
        d_wr_addr = j_reg;
        d_wr_data = demand_reg;

        case (state_reg)
            S_INIT: begin
                q_wr_en    = 1'b1;
                q_wr_addr  = '0;
                q_wr_cost  = '0;
                q_wr_pos   = '0;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    demand_next = in_demand[DW-1:0];
                    fd_next     = in_from_depot;
                    fp_next     = in_from_prev;
                    last_next   = in_last;
                    state_next  = (j_reg == '0) ? S_DEMAND : S_RDMIN;
                end
            end
            S_RDMIN: begin
                q_rd_en     = head_lt_tail;
                detour_next = $signed({2'b00, prev_reg}) + $signed({2'b00, fd_reg})
                            - $signed({2'b00, fp_reg});
                state_next  = S_COST;
            end
            S_COST: begin
                if (cut_cost[COST_W+1]) begin
                    cost_next = '0;
                end else if (cut_cost[COST_W]) begin
                    cost_next = COST_MAX;
                end else begin
                    cost_next = cut_cost[COST_W-1:0];
                end
                state_next = S_BRD;
            end
            S_BRD: begin
                if (tail_reg > head_reg) begin
                    q_rd_en    = 1'b1;
                    q_rd_addr  = AW'(tail_reg - CW'(1));
                    state_next = S_BCMP;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_BCMP: begin
                if (q_rd_cost >= cost_reg) begin
                    tail_next  = tail_reg - CW'(1);
                    state_next = S_BRD;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (tail_reg < CW'(MAX_CLIENTS)) begin
                    q_wr_en   = 1'b1;
                    tail_next = tail_reg + CW'(1);
                end
                state_next = S_DEMAND;
            end
            S_DEMAND: begin
                d_wr_en   = 1'b1;
                load_next = load_reg + LW'(demand_reg);
                if (CAP_W'(demand_reg) > capacity) begin
                    infeas_next = 1'b1;
                end
                state_next = S_DRD;
            end
            S_DRD: begin
                if (load_reg > {1'b0, capacity} && start_reg <= CW'(j_reg)) begin
                    d_rd_en    = 1'b1;
                    q_rd_en    = head_lt_tail;
                    state_next = S_DSUB;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DSUB: begin
                load_next  = load_reg - LW'(d_rd_data);
                if (head_lt_tail && q_rd_pos == start_reg[AW-1:0]) begin
                    head_next = head_reg + CW'(1);
                end
                start_next = start_reg + CW'(1);
                state_next = S_DRD;
            end
            S_FIN: begin
                tl_next = tl_sum[COST_W] ? COST_MAX : tl_sum[COST_W-1:0];
                if (last_reg || j_reg == AW'(MAX_CLIENTS - 1)) begin
                    q_rd_en    = head_lt_tail;
                    state_next = S_TOT1;
                end else begin
                    prev_next  = fd_reg;
                    j_next     = j_reg + AW'(1);
                    state_next = S_IDLE;
                end
            end
            S_TOT1: begin
                sum_next   = min_sum[COST_W] ? COST_MAX : min_sum[COST_W-1:0];
                state_next = S_TOT2;
            end
            S_TOT2: begin
                if (out_free) begin
                    res_valid   = 1'b1;
                    q_wr_en     = 1'b1;
                    q_wr_addr   = '0;
                    q_wr_cost   = '0;
                    q_wr_pos    = '0;
                    head_next   = '0;
                    tail_next   = CW'(1);
                    start_next  = '0;
                    j_next      = '0;
                    load_next   = '0;
                    prev_next   = '0;
                    tl_next     = '0;
                    infeas_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_INIT;
            head_reg   <= '0;
            tail_reg   <= CW'(1);
            start_reg  <= '0;
            j_reg      <= '0;
            load_reg   <= '0;
            prev_reg   <= '0;
            tl_reg     <= '0;
            infeas_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            start_reg  <= start_next;
            j_reg      <= j_next;
            load_reg   <= load_next;
            prev_reg   <= prev_next;
            tl_reg     <= tl_next;
            infeas_reg <= infeas_next;
        end
    end

    always_ff @(posedge aclk) begin
        demand_reg <= demand_next;
        fd_reg     <= fd_next;
        fp_reg     <= fp_next;
        last_reg   <= last_next;
        detour_reg <= detour_next;
        cost_reg   <= cost_next;
        sum_reg    <= sum_next;
    end

endmodule

`default_nettype wire

### rtl/capacitated_route_split_cost_unit.sv
// Per client: a later client of a tour gets its cut cost, drops queue entries from the
// back that are not cheaper and pushes it; every client then drains the load window.
// The last client sums the tour; its result appears on m_tvalid as the input turns
// ready again. Clients are taken one by one; a held result stalls the next last client.
// Reset (synchronous, aresetn low): capacity 100, empty tour, and one cycle after
// release to seed queue entry 0 before the first item is taken.
`default_nettype none

module capacitated_route_split_cost_unit
    import crsc_pkg::*;
#(
    parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
    parameter int DEMAND_BITS = DEMAND_BITS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire  [CAP_W-1:0]    cfg_wr_data,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [79:0]         s_tdata,   // client_demand, dist_from_depot, dist_from_prev
    input  wire                 s_tlast,   // last_client
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [COST_W-1:0]   m_tdata,   // total_cost
    output logic                m_tuser    // infeasible
);

    localparam int AW = $clog2(MAX_CLIENTS);
    localparam int DW = (DEMAND_BITS < DEMAND_W) ? DEMAND_BITS : DEMAND_W;

    logic [CAP_W-1:0]  cap_reg;
    logic              m_tvalid_reg;
    logic [COST_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;
    logic              out_free;
    logic              res_valid;
    result_t           res;

    logic              q_rd_en, q_wr_en, d_rd_en, d_wr_en;
    logic [AW-1:0]     q_rd_addr, q_wr_addr, q_rd_pos, q_wr_pos, d_rd_addr, d_wr_addr;
    logic [COST_W-1:0] q_rd_cost, q_wr_cost;
    logic [DW-1:0]     d_rd_data, d_wr_data;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= res.total_cost;
            m_tuser_reg <= res.infeasible;
        end
    end

    crsc_ctrl #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .DEMAND_BITS (DEMAND_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .capacity      (cap_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_demand     (s_tdata[15:0]),
        .in_from_depot (s_tdata[47:16]),
        .in_from_prev  (s_tdata[79:48]),
        .in_last       (s_tlast),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res),
        .q_rd_en       (q_rd_en),
        .q_rd_addr     (q_rd_addr),
        .q_rd_cost     (q_rd_cost),
        .q_rd_pos      (q_rd_pos),
        .q_wr_en       (q_wr_en),
        .q_wr_addr     (q_wr_addr),
        .q_wr_cost     (q_wr_cost),
        .q_wr_pos      (q_wr_pos),
        .d_rd_en       (d_rd_en),
        .d_rd_addr     (d_rd_addr),
        .d_rd_data     (d_rd_data),
        .d_wr_en       (d_wr_en),
        .d_wr_addr     (d_wr_addr),
        .d_wr_data     (d_wr_data)
    );

    crsc_store #(
        .DEPTH (MAX_CLIENTS),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .aclk      (aclk),
        .q_rd_en   (q_rd_en),
        .q_rd_addr (q_rd_addr),
        .q_rd_cost (q_rd_cost),
        .q_rd_pos  (q_rd_pos),
        .q_wr_en   (q_wr_en),
        .q_wr_addr (q_wr_addr),
        .q_wr_cost (q_wr_cost),
        .q_wr_pos  (q_wr_pos),
        .d_rd_en   (d_rd_en),
        .d_rd_addr (d_rd_addr),
        .d_rd_data (d_rd_data),
        .d_wr_en   (d_wr_en),
        .d_wr_addr (d_wr_addr),
        .d_wr_data (d_wr_data)
    );

endmodule

`default_nettype wire

### sim/capacitated_route_split_cost_unit_tb.sv
// Self-checking testbench for the route split cost unit: random tours and capacities vs. predictor.
`timescale 1ns / 100ps

module capacitated_route_split_cost_unit_tb;
    import crsc_pkg::*;

    localparam int NCLIENT = MAX_CLIENTS_DEF;

    typedef struct {
        bit [DEMAND_W-1:0] demand;
        bit [DIST_W-1:0]   depot;
        bit [DIST_W-1:0]   hop;
        bit                last;
    } client_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [79:0]         s_tdata = '0;   // client_demand, dist_from_depot, dist_from_prev
    logic                s_tlast = 1'b0; // last_client
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [COST_W-1:0]   m_tdata;        // total_cost
    logic                m_tuser;        // infeasible

    capacitated_route_split_cost_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #10 aclk = ~aclk;

    // predictor state
    bit [COST_W-1:0]   split_cost_q [0:NCLIENT-1];
    bit [9:0]          split_pos_q  [0:NCLIENT-1];
    bit [DEMAND_W-1:0] demand_mem   [0:NCLIENT-1];
    bit [10:0]         split_head;
    bit [10:0]         split_tail;
    bit [10:0]         win_first;
    bit [10:0]         cut_idx;
    bit [CAP_W:0]      win_load;
    bit [DIST_W-1:0]   prev_depot;
    bit [COST_W-1:0]   tour_len;
    bit                infeas_seen;
    bit [CAP_W-1:0]    route_cap = CAP_RESET;

    client_t client_queue[$];
    result_t expected_totals[$];
    client_t cur_client;
    bit      idle_en = 1'b1;
    int      error_count = 0;

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic bit [COST_W-1:0] sat_add(bit [COST_W-1:0] a, bit [COST_W-1:0] b);
        bit [COST_W:0] s;
        s = a + b;
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

    function automatic bit [COST_W-1:0] split_min();
        if (split_head < split_tail && split_head < NCLIENT)
            return split_cost_q[split_head[9:0]];
        return '0;
    endfunction

    function automatic void clear_tour();
        split_cost_q[0] = '0;
        split_pos_q[0] = '0;
        split_head = '0;
        split_tail = 11'd1;
        win_first = '0;
        cut_idx = '0;
        win_load = '0;
        prev_depot = '0;
        tour_len = '0;
        infeas_seen = 1'b0;
    endfunction

    function automatic void advance_split(client_t c);
        longint          d;
        bit [COST_W-1:0] cost;
        result_t         res;
        bit [10:0]       j;
        bit              ends;
        j = cut_idx;
        ends = c.last || (j >= NCLIENT - 1);
        if (j != 0) begin
            d = $signed({16'h0, split_min()}) + $signed({32'h0, prev_depot})
              + $signed({32'h0, c.depot}) - $signed({32'h0, c.hop});
            if (d < 0)
                cost = '0;
            else if (d[63:COST_W] != 0)
                cost = COST_MAX;
            else
                cost = d[COST_W-1:0];
            while (split_tail > split_head && split_cost_q[10'(split_tail - 11'd1)] >= cost)
                split_tail--;
            if (split_tail < NCLIENT) begin
                split_cost_q[split_tail[9:0]] = cost;
                split_pos_q[split_tail[9:0]] = j[9:0];
                split_tail++;
            end
        end
        demand_mem[j[9:0]] = c.demand;
        win_load += c.demand;
        if (c.demand > route_cap)
            infeas_seen = 1'b1;
        while (win_load > route_cap && win_first <= j) begin
            win_load -= demand_mem[win_first[9:0]];
            if (split_head < split_tail && split_head < NCLIENT
                && split_pos_q[split_head[9:0]] == win_first)
                split_head++;
            win_first++;
        end
        tour_len = sat_add(tour_len, c.hop);
        if (ends) begin
            res.total_cost = infeas_seen ? '0 : sat_add(sat_add(split_min(), tour_len), c.depot);
            res.infeasible = infeas_seen;
            expected_totals.insert(expected_totals.size(), res);
            clear_tour();
        end else begin
            prev_depot = c.depot;
            cut_idx = j + 11'd1;
        end
    endfunction

    always @(posedge aclk) begin : client_driver
        client_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                advance_split(cur_client);
            if (!s_tvalid || s_tready) begin
                if (client_queue.size() != 0 && (!idle_en || $urandom_range(0, 99) >= 36)) begin
                    nxt = client_queue.pop_front();
                    cur_client = nxt;
                    s_tdata <= {nxt.hop, nxt.depot, nxt.demand};
                    s_tlast <= nxt.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_totals.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: cost=%h infeasible=%b",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_totals.pop_front();
                    if (m_tdata !== want.total_cost)
                        report_mismatch($sformatf("total_cost %h, want %h",
                                                  m_tdata, want.total_cost));
                    if (m_tuser !== want.infeasible)
                        report_mismatch($sformatf("infeasible %b, want %b",
                                                  m_tuser, want.infeasible));
                end
            end
            m_tready <= !idle_en || ($urandom_range(0, 99) >= 36);
        end
    end

    task automatic add_client(int unsigned demand, bit [31:0] depot, bit [31:0] hop, bit last);
        client_t c;
        c.demand = demand[DEMAND_W-1:0];
        c.depot = depot;
        c.hop = hop;
        c.last = last;
        client_queue.insert(client_queue.size(), c);
    endtask

    function automatic int unsigned pick_demand(bit [CAP_W-1:0] cap);
        int unsigned r;
        int unsigned lim;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 65535;
        if (r < 8)
            return 1;
        if (r < 12 && cap < 65535)
            return $urandom_range(cap + 1, 65535);
        lim = (cap > 196605) ? 65535 : cap / 3;
        if (lim < 1)
            lim = 1;
        return $urandom_range(1, lim);
    endfunction

    function automatic bit [31:0] pick_dist();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'h0;
        if (r < 16)
            return 32'hFFFF_FFFF;
        if (r < 28)
            return $urandom;
        return $urandom_range(0, 32'h00FF_FFFF);
    endfunction

    task automatic add_random_tour(inout int count);
        int unsigned r;
        int          len;
        r = $urandom_range(0, 99);
        if (r < 10)
            len = 1;
        else if (r < 80)
            len = $urandom_range(2, 12);
        else
            len = $urandom_range(13, 60);
        for (int k = 0; k < len; k++)
            add_client(pick_demand(route_cap), pick_dist(), pick_dist(), k == len - 1);
        count += len;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (client_queue.size() != 0 || s_tvalid || expected_totals.size() != 0);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_capacity(bit [CAP_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        route_cap = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        bit [CAP_W-1:0] caps [7];
        int             count;
        caps = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1000, 32'd65535, 32'd0, 32'd100};
        clear_tour();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, capacity 100
        add_client(1, 0, 0, 1);
        add_client(30, 10 << 16, 10 << 16, 0);
        add_client(30, 12 << 16, 3 << 16, 0);
        add_client(40, 8 << 16, 5 << 16, 1);
        // full-load clients, extreme distances
        add_client(100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_client(100, 32'hFFFF_FFFF, 32'h0, 0);
        add_client(1, 32'h0, 32'hFFFF_FFFF, 1);
        // oversized client mid-tour
        add_client(60, 5 << 16, 5 << 16, 0);
        add_client(65535, 7 << 16, 2 << 16, 0);
        add_client(20, 3 << 16, 4 << 16, 1);
        // window shrink
        add_client(50, 32'h1, 32'hFFFF_FFFF, 0);
        add_client(50, 32'hFFFF_FFFF, 32'h1, 0);
        add_client(51, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        add_client(101, 0, 0, 1);

        for (int p = 0; p < 7; p++) begin
            wait_idle();
            set_capacity(p == 5 ? 32'($urandom_range(2, 5000)) : caps[p]);
            idle_en = (p != 0);
            count = 0;
            if (p == 0) begin
                // overlong tour: never flagged last, ends at the last slot
                for (int k = 0; k < NCLIENT; k++)
                    add_client(pick_demand(route_cap), $urandom_range(32'h1_0000, 32'h40_0000),
                               $urandom_range(0, 32'hFFFF), 1'b0);
            end
            while (count < 110)
                add_random_tour(count);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("capacitated_route_split_cost_unit_tb: done, clean");
        end else begin
            $display("capacitated_route_split_cost_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("capacitated_route_split_cost_unit_tb: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/crsc_pkg.sv
rtl/crsc_store.sv
rtl/crsc_ctrl.sv
rtl/capacitated_route_split_cost_unit.sv
sim/capacitated_route_split_cost_unit_tb.sv
